/* rtl/core/ede_pkg.sv */
// Shared types and codes for the edit distance engine.
// Holds the command and result transaction structs, the function codes and the
// sequencer state type. No dependencies.
package ede_pkg;

  localparam logic [1:0] FUNC_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_SECOND = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
  } cmd_t;

  typedef struct packed {
    logic [6:0] distance;
    logic       overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FIN
  } state_t;

endpackage

/* rtl/core/ede_cell.sv */
// Shared cost update unit: minimum of the three edit paths for one column entry.
// Used once per cycle by the column pass in edit_distance_engine. No package use.
module ede_cell #(
  parameter int CW = 7
) (
  input  logic [CW-1:0] up,
  input  logic [CW-1:0] left,
  input  logic [CW-1:0] diag,
  input  logic          match,
  output logic [CW-1:0] cost
);

  logic [CW:0] del_cost;
  logic [CW:0] ins_cost;
  logic [CW:0] sub_cost;
  logic [CW:0] min_a;
  logic [CW:0] min_b;

  assign del_cost = {1'b0, up} + 1'b1;
  assign ins_cost = {1'b0, left} + 1'b1;
  assign sub_cost = {1'b0, diag} + {{CW{1'b0}}, ~match};

  assign min_a = (del_cost < ins_cost) ? del_cost : ins_cost;
  assign min_b = (min_a < sub_cost) ? min_a : sub_cost;

  // Column entries never exceed the longest string length, so the top bit drops.
  assign cost = min_b[CW-1:0];

endmodule

/* rtl/core/edit_distance_engine.sv */
// Edit distance engine: single-column dynamic programme over two symbol strings.
// Depends on ede_pkg and ede_cell.
//
// Usage: drive cmd with a transaction and raise start; the command is taken at
// a rising edge where start is high and busy is low.
//   func FIRST  : store a first-string symbol; busy stays low.
//   func SECOND : advance the cost column by one second-string symbol; the
//                 single shared cost unit updates one column entry per cycle
//                 off a registered memory read, for each of the L entries of
//                 the first string. busy is high during the pass.
//   func FINISH : done pulses with result in the next cycle when the first string
//                 is empty, otherwise after a column memory read in ST_FIN;
//                 the block then clears for the next pair.
// Symbols past MAX_LEN in either string are dropped and set result.overflow.
// result is valid only in the cycle done is high; the receiver cannot stall,
// so each result is presented exactly once.
// Reset (rst, synchronous) clears lengths, the overflow flag and the sequencer;
// the symbol and column memories need no clearing.
module edit_distance_engine #(
  parameter int MAX_LEN = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ede_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done,
  output ede_pkg::result_t result
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int SW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = LW;

  ede_pkg::state_t state;
  ede_pkg::state_t state_next;

  logic [LW-1:0] first_length;
  logic [LW-1:0] first_length_next;
  logic [LW-1:0] second_count;
  logic [LW-1:0] second_count_next;
  logic          overflow_flag;
  logic          overflow_flag_next;
  logic [LW-1:0] y_idx;
  logic [LW-1:0] y_idx_next;
  logic [CW-1:0] left;
  logic [CW-1:0] left_next;
  logic [CW-1:0] diag;
  logic [CW-1:0] diag_next;
  logic [7:0]    cur_symbol;
  logic [7:0]    cur_symbol_next;
  logic          done_next;
  ede_pkg::result_t result_next;

  logic [7:0]    sym_mem [MAX_LEN];
  logic [CW-1:0] cost_mem [MAX_LEN+1];
  logic [7:0]    sym_q;
  logic [CW-1:0] cost_q;

  logic [LW-1:0] rd_addr;
  logic [LW-1:0] sym_rd_full;
  logic [SW-1:0] sym_ra;
  logic          sym_we;
  logic [SW-1:0] sym_wa;
  logic          cost_we;
  logic [LW-1:0] cost_wa;
  logic [CW-1:0] cost_wd;

  logic [CW-1:0] cell_cost;
  logic [LW+6:0] count_ext;
  logic [CW+6:0] cost_ext;

  ede_cell #(
    .CW (CW)
  ) u_cell (
    .up    (cost_q),
    .left  (left),
    .diag  (diag),
    .match (sym_q == cur_symbol),
    .cost  (cell_cost)
  );

  assign sym_rd_full = (rd_addr == '0) ? '0 : rd_addr - 1'b1;
  assign sym_ra      = sym_rd_full[SW-1:0];
  assign count_ext   = {7'd0, second_count};
  assign cost_ext    = {7'd0, cost_q};
  assign busy        = (state != ede_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= cmd.symbol;
    end
    sym_q <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[cost_wa] <= cost_wd;
    end
    cost_q <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ede_pkg::ST_IDLE;
      first_length  <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      first_length  <= first_length_next;
      second_count  <= second_count_next;
      overflow_flag <= overflow_flag_next;
      done          <= done_next;
    end
    y_idx      <= y_idx_next;
    left       <= left_next;
    diag       <= diag_next;
    cur_symbol <= cur_symbol_next;
    result     <= result_next;
  end

  always_comb begin
    state_next         = state;
    first_length_next  = first_length;
    second_count_next  = second_count;
    overflow_flag_next = overflow_flag;
    y_idx_next         = y_idx;
    left_next          = left;
    diag_next          = diag;
    cur_symbol_next    = cur_symbol;
    done_next          = 1'b0;
    result_next        = result;
    rd_addr            = '0;
    sym_we             = 1'b0;
    sym_wa             = first_length[SW-1:0];
    cost_we            = 1'b0;
    cost_wa            = '0;
    cost_wd            = '0;

    case (state)
      ede_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd.func)
            ede_pkg::FUNC_FIRST: begin
              // Drop first symbols once the column has been advanced.
              if (second_count == '0) begin
                if (first_length >= LW'(MAX_LEN)) begin
                  overflow_flag_next = 1'b1;
                end else begin
                  sym_we            = 1'b1;
                  cost_we           = 1'b1;
                  cost_wa           = first_length + 1'b1;
                  cost_wd           = first_length + 1'b1;
                  first_length_next = first_length + 1'b1;
                end
              end
            end
            ede_pkg::FUNC_SECOND: begin
              if (second_count >= LW'(MAX_LEN)) begin
                overflow_flag_next = 1'b1;
              end else begin
                cost_we           = 1'b1;
                cost_wa           = '0;
                cost_wd           = second_count + 1'b1;
                left_next         = second_count + 1'b1;
                diag_next         = second_count;
                second_count_next = second_count + 1'b1;
                cur_symbol_next   = cmd.symbol;
                y_idx_next        = LW'(1);
                rd_addr           = LW'(1);
                if (first_length != '0) begin
                  state_next = ede_pkg::ST_PASS;
                end
              end
            end
            ede_pkg::FUNC_FINISH: begin
              result_next.overflow = overflow_flag;
              if (first_length == '0) begin
                done_next            = 1'b1;
                result_next.distance = count_ext[6:0];
              end else begin
                rd_addr    = first_length;
                state_next = ede_pkg::ST_FIN;
              end
              first_length_next  = '0;
              second_count_next  = '0;
              overflow_flag_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ede_pkg::ST_PASS: begin
        // Write entry y and fetch entry y+1 in the same cycle.
        cost_we   = 1'b1;
        cost_wa   = y_idx;
        cost_wd   = cell_cost;
        left_next = cell_cost;
        diag_next = cost_q;
        if (y_idx == first_length) begin
          state_next = ede_pkg::ST_IDLE;
        end else begin
          y_idx_next = y_idx + 1'b1;
          rd_addr    = y_idx + 1'b1;
        end
      end
      ede_pkg::ST_FIN: begin
        done_next            = 1'b1;
        result_next.distance = cost_ext[6:0];
        state_next           = ede_pkg::ST_IDLE;
      end
      default: begin
        state_next = ede_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
